>>> design/tlvx_pkg.sv
// Shared types and constants for the TLV record value extractor.
// Used by the configuration, scanner, result queue and top-level files.
package tlvx_pkg;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Register indexes on the configuration port (byte address = 4 * index).
  localparam logic [1:0] REG_TAG_FIRST    = 2'd0;
  localparam logic [1:0] REG_TAG_SECOND   = 2'd1;
  localparam logic [1:0] REG_LENGTH_MODE  = 2'd2;
  localparam logic [1:0] REG_LENGTH_BOUND = 2'd3;

  // Scan phases.
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_VALUE  = 2'd1;
  localparam logic [1:0] PH_SKIP   = 2'd2;
  localparam logic [1:0] PH_DRAIN  = 2'd3;

  // Header byte positions: tag low, tag high, length low, length high.
  localparam logic [1:0] HDR_TAG0 = 2'd0;
  localparam logic [1:0] HDR_TAG1 = 2'd1;
  localparam logic [1:0] HDR_LEN0 = 2'd2;
  localparam logic [1:0] HDR_LEN1 = 2'd3;

  typedef struct packed {
    logic [7:0]  tag_first;
    logic [7:0]  tag_second;
    logic        length_mode;
    logic [15:0] length_bound;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  value_byte;
    logic        is_value;
    logic        done_res;
    logic        found;
    logic [15:0] record_length;
  } res_t;

endpackage

>>> design/tlvx_cfg.sv
// Configuration register file with an APB-style access port.
// Depends on tlvx_pkg for the register indexes and the cfg_t struct.
module tlvx_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tlvx_pkg::CFG_AW-1:0] paddr,
  input  logic [tlvx_pkg::CFG_DW-1:0] pwdata,
  output logic [tlvx_pkg::CFG_DW-1:0] prdata,
  output tlvx_pkg::cfg_t             cfg
);
  import tlvx_pkg::*;

  cfg_t       cfg_r;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tag_first    <= 8'd0;
      cfg_r.tag_second   <= 8'd0;
      cfg_r.length_mode  <= 1'b0;
      cfg_r.length_bound <= 16'd1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TAG_FIRST:    cfg_r.tag_first    <= pwdata[7:0];
        REG_TAG_SECOND:   cfg_r.tag_second   <= pwdata[7:0];
        REG_LENGTH_MODE:  cfg_r.length_mode  <= pwdata[0];
        REG_LENGTH_BOUND: cfg_r.length_bound <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_TAG_FIRST:    prdata[7:0]  = cfg_r.tag_first;
      REG_TAG_SECOND:   prdata[7:0]  = cfg_r.tag_second;
      REG_LENGTH_MODE:  prdata[0]    = cfg_r.length_mode;
      REG_LENGTH_BOUND: prdata[15:0] = cfg_r.length_bound;
      default: ;
    endcase
  end

endmodule

>>> design/tlvx_scan.sv
// Per-byte TLV scanner: header parsing, tag and length match, value and skip counting.
// Depends on tlvx_pkg for phase codes and the cfg_t and res_t structs.
module tlvx_scan (
  input  logic           clk,
  input  logic           rst_n,
  input  tlvx_pkg::cfg_t cfg,
  input  logic           step,
  input  logic [7:0]     data_byte,
  input  logic           last_in_buffer,
  output logic           res_valid,
  output tlvx_pkg::res_t res
);
  import tlvx_pkg::*;

  logic [1:0]  phase_r, phase_nxt;
  logic [1:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic        tag_match_r, tag_match_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [15:0] held_len_r, held_len_nxt;
  logic [15:0] remain_r, remain_nxt;

  logic [15:0] hdr_len;
  logic        len_ok;
  logic [15:0] remain_dec;

  assign hdr_len    = {data_byte, len_lo_r};
  assign len_ok     = cfg.length_mode ? (hdr_len <= cfg.length_bound)
                                      : (hdr_len == cfg.length_bound);
  assign remain_dec = (remain_r != 16'd0) ? remain_r - 16'd1 : remain_r;

  always_comb begin
    phase_nxt     = phase_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    tag_match_nxt = tag_match_r;
    len_lo_nxt    = len_lo_r;
    held_len_nxt  = held_len_r;
    remain_nxt    = remain_r;
    res_valid     = 1'b0;
    res           = '0;

    unique case (phase_r)
      PH_HEADER: begin
        if (last_in_buffer) begin
          // The buffer ended inside a header.
          hdr_cnt_nxt   = HDR_TAG0;
          tag_match_nxt = 1'b0;
          res_valid     = 1'b1;
          res.done_res  = 1'b1;
        end else begin
          unique case (hdr_cnt_r)
            HDR_TAG0: begin
              tag_match_nxt = (data_byte == cfg.tag_first);
              hdr_cnt_nxt   = HDR_TAG1;
            end
            HDR_TAG1: begin
              tag_match_nxt = tag_match_r && (data_byte == cfg.tag_second);
              hdr_cnt_nxt   = HDR_LEN0;
            end
            HDR_LEN0: begin
              len_lo_nxt  = data_byte;
              hdr_cnt_nxt = HDR_LEN1;
            end
            HDR_LEN1: begin
              held_len_nxt  = hdr_len;
              hdr_cnt_nxt   = HDR_TAG0;
              tag_match_nxt = 1'b0;
              if (tag_match_r && len_ok) begin
                if (hdr_len == 16'd0) begin
                  // An empty matching record is reported right away.
                  phase_nxt     = PH_DRAIN;
                  res_valid     = 1'b1;
                  res.done_res  = 1'b1;
                  res.found     = 1'b1;
                end else begin
                  phase_nxt  = PH_VALUE;
                  remain_nxt = hdr_len;
                end
              end else if (hdr_len != 16'd0) begin
                phase_nxt  = PH_SKIP;
                remain_nxt = hdr_len;
              end
            end
            default: ;
          endcase
        end
      end

      PH_VALUE: begin
        remain_nxt     = remain_dec;
        res_valid      = 1'b1;
        res.value_byte = data_byte;
        res.is_value   = 1'b1;
        if (remain_dec == 16'd0) begin
          res.done_res      = 1'b1;
          res.found         = 1'b1;
          res.record_length = held_len_r;
          if (last_in_buffer) begin
            phase_nxt     = PH_HEADER;
            hdr_cnt_nxt   = HDR_TAG0;
            tag_match_nxt = 1'b0;
          end else begin
            phase_nxt = PH_DRAIN;
          end
        end else if (last_in_buffer) begin
          // The value runs past the end of the buffer.
          res.done_res  = 1'b1;
          phase_nxt     = PH_HEADER;
          hdr_cnt_nxt   = HDR_TAG0;
          tag_match_nxt = 1'b0;
        end
      end

      PH_SKIP: begin
        remain_nxt = remain_dec;
        if (last_in_buffer) begin
          res_valid     = 1'b1;
          res.done_res  = 1'b1;
          phase_nxt     = PH_HEADER;
          hdr_cnt_nxt   = HDR_TAG0;
          tag_match_nxt = 1'b0;
        end else if (remain_dec == 16'd0) begin
          phase_nxt     = PH_HEADER;
          hdr_cnt_nxt   = HDR_TAG0;
          tag_match_nxt = 1'b0;
        end
      end

      PH_DRAIN: begin
        if (last_in_buffer) begin
          phase_nxt     = PH_HEADER;
          hdr_cnt_nxt   = HDR_TAG0;
          tag_match_nxt = 1'b0;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      hdr_cnt_r   <= HDR_TAG0;
      tag_match_r <= 1'b0;
      len_lo_r    <= 8'd0;
      held_len_r  <= 16'd0;
      remain_r    <= 16'd0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      tag_match_r <= tag_match_nxt;
      len_lo_r    <= len_lo_nxt;
      held_len_r  <= held_len_nxt;
      remain_r    <= remain_nxt;
    end
  end

endmodule

>>> design/tlvx_outq.sv
// Two-entry result queue: an output register plus a skid entry.
// Depends on tlvx_pkg for the res_t struct.
module tlvx_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tlvx_pkg::res_t din,
  output logic           has_space,
  output logic           out_valid,
  input  logic           out_ready,
  output tlvx_pkg::res_t dout
);
  import tlvx_pkg::*;

  res_t       head_r;
  res_t       skid_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign has_space = (cnt_r != 2'd2);
  assign dout      = head_r;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt_r == 2'd2) begin
        head_r <= skid_r;
        if (push) begin
          skid_r <= din;
        end
      end else if (push) begin
        head_r <= din;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        head_r <= din;
      end else begin
        skid_r <= din;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (push && !pop) begin
      cnt_r <= cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

>>> design/tlv_record_value_extractor.sv
// TLV record value extractor.
//
// Input channel (in_valid/in_ready): one buffer byte per request, with
// in_last_in_buffer marking the final byte of a buffer. The block scans for
// the first record whose two tag bytes and 16-bit little-endian length match
// the configuration, forwards its value bytes, and ends the search with a
// done result that says found (with the length) or not found.
// Output channel (out_valid/out_ready): at most one result per input byte.
// A byte is captured in the input register; the scanner handles it from
// there when the result queue has space and writes its result into the queue.
// Throughput is one byte per cycle while the result queue has space.
// A two-entry result queue lets the block keep taking bytes while one result
// waits; when the receiver stalls, the queue fills and in_ready drops.
// Reset (synchronous, rst_n low) sets the registers to their defaults
// (length_bound = 1, others 0), empties the pipeline and restarts the scan.
// Configuration is written through psel/penable/pwrite/paddr/pwdata and
// takes effect at once; write it only while no request is in flight.
// Depends on tlvx_pkg, tlvx_cfg, tlvx_scan and tlvx_outq.
module tlv_record_value_extractor (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tlvx_pkg::CFG_AW-1:0] paddr,
  input  logic [tlvx_pkg::CFG_DW-1:0] pwdata,
  output logic [tlvx_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_last_in_buffer,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_value_byte,
  output logic                        out_is_value,
  output logic                        out_done_res,
  output logic                        out_found,
  output logic [15:0]                 out_record_length
);
  import tlvx_pkg::*;

  cfg_t       cfg;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_fire;
  logic       q_space;
  logic       res_valid;
  res_t       res;
  res_t       q_out;

  assign pready   = 1'b1;
  assign s1_fire  = s1_valid_r && q_space;
  assign in_ready = !s1_valid_r || s1_fire;

  tlvx_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_in_buffer;
    end
  end

  tlvx_scan u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .step           (s1_fire),
    .data_byte      (s1_byte_r),
    .last_in_buffer (s1_last_r),
    .res_valid      (res_valid),
    .res            (res)
  );

  tlvx_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_fire && res_valid),
    .din       (res),
    .has_space (q_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (q_out)
  );

  assign out_value_byte    = q_out.value_byte;
  assign out_is_value      = q_out.is_value;
  assign out_done_res      = q_out.done_res;
  assign out_found         = q_out.found;
  assign out_record_length = q_out.record_length;

  // A held input byte must stay put until the scanner takes it.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> s1_valid_r && $stable(s1_byte_r) && $stable(s1_last_r))
    else $error("input register lost or changed a waiting byte");

  // An empty input register always takes a new byte.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input not ready with an empty input register");

  // A found status only comes with the end of the search.
  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_done_res)
    else $error("found reported without done");

  // Non-value results carry a zero value byte.
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_value |-> out_value_byte == 8'd0)
    else $error("value byte set on a status-only result");

endmodule

>>> tb/tb_tlv_record_value_extractor.sv
`timescale 1ns / 1ps
// Self-checking testbench for tlv_record_value_extractor: random TLV buffers in,
// results checked against an in-bench scan predictor. Depends on tlvx_pkg and the RTL.
module tb_tlv_record_value_extractor;
  import tlvx_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_in_buffer = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_value_byte;
  logic        out_is_value;
  logic        out_done_res;
  logic        out_found;
  logic [15:0] out_record_length;

  tlv_record_value_extractor uut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_data_byte(in_data_byte),
    .in_last_in_buffer(in_last_in_buffer),
    .out_valid(out_valid), .out_ready(out_ready), .out_value_byte(out_value_byte),
    .out_is_value(out_is_value), .out_done_res(out_done_res), .out_found(out_found),
    .out_record_length(out_record_length)
  );

  // Shadow copy of the registers.
  logic [7:0]  want_tag0 = 8'h00;
  logic [7:0]  want_tag1 = 8'h00;
  logic        at_most = 1'b0;
  logic [15:0] len_limit = 16'd1;

  // Predicted scanner state.
  logic [1:0]  scan_ph = PH_HEADER;
  logic [1:0]  hdr_pos = HDR_TAG0;
  logic        tag_hit = 1'b0;
  logic [7:0]  len_lo = 8'h00;
  logic [15:0] rec_len = 16'h0000;
  logic [15:0] left_cnt = 16'h0000;

  in_byte_t byte_queue[$];
  res_t     pending_results[$];

  int  err_count = 0;
  int  bytes_taken = 0;
  int  value_count = 0;
  int  found_count = 0;
  int  miss_count = 0;
  int  rand_items = 0;
  int  settings = 1;
  int  in_gap = 0;
  int  out_gap = 0;
  bit  idle_on = 1'b1;
  bit  in_fire = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report(input string msg);
    err_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  function automatic void rescan();
    scan_ph = PH_HEADER;
    hdr_pos = HDR_TAG0;
    tag_hit = 1'b0;
  endfunction

  // Advances the predicted scan by one accepted byte and queues its result.
  task automatic scan_byte(input logic [7:0] b, input logic last);
    res_t r;
    bit   emit;
    bit   accept;
    r = '0;
    emit = 1'b0;
    case (scan_ph)
      PH_HEADER: begin
        if (last) begin
          rescan();
          r.done_res = 1'b1;
          emit = 1'b1;
        end else begin
          case (hdr_pos)
            HDR_TAG0: begin
              tag_hit = (b == want_tag0);
              hdr_pos = HDR_TAG1;
            end
            HDR_TAG1: begin
              tag_hit = tag_hit && (b == want_tag1);
              hdr_pos = HDR_LEN0;
            end
            HDR_LEN0: begin
              len_lo = b;
              hdr_pos = HDR_LEN1;
            end
            default: begin
              rec_len = {b, len_lo};
              hdr_pos = HDR_TAG0;
              accept = at_most ? (rec_len <= len_limit) : (rec_len == len_limit);
              if (tag_hit && accept) begin
                if (rec_len == 16'd0) begin
                  // A zero-length match completes on its last header byte.
                  scan_ph = PH_DRAIN;
                  r.done_res = 1'b1;
                  r.found = 1'b1;
                  emit = 1'b1;
                end else begin
                  scan_ph = PH_VALUE;
                  left_cnt = rec_len;
                end
              end else if (rec_len != 16'd0) begin
                scan_ph = PH_SKIP;
                left_cnt = rec_len;
              end
              tag_hit = 1'b0;
            end
          endcase
        end
      end
      PH_VALUE: begin
        if (left_cnt != 16'd0) left_cnt--;
        r.value_byte = b;
        r.is_value = 1'b1;
        emit = 1'b1;
        if (left_cnt == 16'd0) begin
          if (last) rescan();
          else scan_ph = PH_DRAIN;
          r.done_res = 1'b1;
          r.found = 1'b1;
          r.record_length = rec_len;
        end else if (last) begin
          // The value runs past the buffer end.
          rescan();
          r.done_res = 1'b1;
        end
      end
      PH_SKIP: begin
        if (left_cnt != 16'd0) left_cnt--;
        if (last) begin
          rescan();
          r.done_res = 1'b1;
          emit = 1'b1;
        end else if (left_cnt == 16'd0) begin
          rescan();
        end
      end
      default: begin
        if (last) rescan();
      end
    endcase
    if (emit) pending_results.push_back(r);
  endtask

  // Input side: a new request is offered only once the previous one was taken.
  always @(negedge clk) begin : drive
    in_byte_t nxt;
    if (rst_n && !(in_valid && !in_fire)) begin
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        in_gap <= $urandom_range(0, 9);
        in_valid <= 1'b0;
      end else if (byte_queue.size() != 0) begin
        nxt = byte_queue.pop_front();
        in_valid <= 1'b1;
        in_data_byte <= nxt.data;
        in_last_in_buffer <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_gap != 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_gap <= $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        scan_byte(in_data_byte, in_last_in_buffer);
        bytes_taken++;
      end
      if (out_valid && out_ready) begin
        got = {out_value_byte, out_is_value, out_done_res, out_found, out_record_length};
        if (pending_results.size() == 0) begin
          report($sformatf("unexpected result byte=%02h val=%b done=%b found=%b len=%0d",
                           got.value_byte, got.is_value, got.done_res, got.found,
                           got.record_length));
        end else begin
          want = pending_results.pop_front();
          if (got.value_byte !== want.value_byte || got.is_value !== want.is_value ||
              got.done_res !== want.done_res || got.found !== want.found ||
              got.record_length !== want.record_length)
            report($sformatf("got byte=%02h val=%b done=%b found=%b len=%0d, want %02h %b %b %b %0d",
                             got.value_byte, got.is_value, got.done_res, got.found,
                             got.record_length, want.value_byte, want.is_value,
                             want.done_res, want.found, want.record_length));
          if (want.is_value) value_count++;
          if (want.done_res && want.found) found_count++;
          if (want.done_res && !want.found) miss_count++;
        end
      end
    end
  end

  // Writes a register, updates the shadow copy, then reads it back.
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] val);
    logic [CFG_DW-1:0] kept;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    kept = '0;
    case (idx)
      REG_TAG_FIRST: begin
        want_tag0 = val[7:0];
        kept[7:0] = val[7:0];
      end
      REG_TAG_SECOND: begin
        want_tag1 = val[7:0];
        kept[7:0] = val[7:0];
      end
      REG_LENGTH_MODE: begin
        at_most = val[0];
        kept[0] = val[0];
      end
      default: begin
        len_limit = val[15:0];
        kept[15:0] = val[15:0];
      end
    endcase
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== kept)
      report($sformatf("register %0d reads %h, want %h", idx, prdata, kept));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Upper bits of the write data are sometimes filled with noise; they must be dropped.
  task automatic set_config(input logic [7:0] t0, input logic [7:0] t1, input logic mode,
                            input logic [15:0] bound);
    logic [CFG_DW-1:0] junk;
    junk = ($urandom_range(0, 1) == 0) ? '0 : $urandom;
    write_reg(REG_TAG_FIRST, {junk[31:8], t0});
    write_reg(REG_TAG_SECOND, {junk[31:8], t1});
    write_reg(REG_LENGTH_MODE, {junk[31:1], mode});
    write_reg(REG_LENGTH_BOUND, {junk[31:16], bound});
    settings++;
  endtask

  task automatic send_bytes(input logic [95:0] v, input int n);
    in_byte_t it;
    for (int i = 0; i < n; i++) begin
      it.data = v[8*(n-1-i) +: 8];
      it.last = (i == n - 1);
      byte_queue.push_back(it);
    end
  endtask

  // Builds one buffer of records for the current setting, sometimes cut short.
  task automatic queue_buffer();
    logic [7:0]  bytes[$];
    logic [7:0]  t0;
    logic [7:0]  t1;
    logic [15:0] len;
    in_byte_t    it;
    int          cap;
    int          nrec;
    int          kind;
    int          n;
    cap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : $urandom_range(24, 72);
    nrec = $urandom_range(1, 4);
    for (int r = 0; r < nrec && bytes.size() < cap; r++) begin
      kind = $urandom_range(0, 9);
      t0 = want_tag0;
      t1 = want_tag1;
      if (at_most)
        len = ($urandom_range(0, 3) == 0) ? len_limit :
              $urandom_range(0, (len_limit < 12) ? len_limit : 12);
      else
        len = len_limit;
      case (kind)
        0, 1: t0 = t0 ^ $urandom_range(1, 255);
        2, 3: t1 = t1 ^ $urandom_range(1, 255);
        4: begin
          if (at_most) len = len_limit + $urandom_range(1, 3);
          else len = ($urandom_range(0, 1) == 0) ? len_limit + 16'd1 : len_limit - 16'd1;
        end
        5: begin
          t0 = $urandom_range(0, 255);
          t1 = $urandom_range(0, 255);
          len = $urandom_range(0, 65535);
        end
        default: ;
      endcase
      bytes.push_back(t0);
      bytes.push_back(t1);
      bytes.push_back(len[7:0]);
      bytes.push_back(len[15:8]);
      for (int k = 0; k < len && bytes.size() < cap; k++)
        bytes.push_back($urandom_range(0, 255));
    end
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 6)) bytes.push_back($urandom_range(0, 255));
    n = (bytes.size() < cap) ? bytes.size() : cap;
    if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
    for (int i = 0; i < n; i++) begin
      it.data = bytes[i];
      it.last = (i == n - 1);
      byte_queue.push_back(it);
    end
    rand_items += n;
  endtask

  // Waits until every queued byte is sent and every predicted result has arrived, then idles for margin.
  task automatic wait_quiet();
    while (byte_queue.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int target;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset setting: tag 00 00, exact length 1.
    send_bytes(96'hFF, 1);
    send_bytes(96'h0000_0100, 4);
    send_bytes(96'h0000_0100_FF55_AA, 7);
    wait_quiet();

    set_config(8'hA5, 8'h5A, 1'b0, 16'd0);
    send_bytes(96'hA55A_0000_77, 5);
    wait_quiet();

    set_config(8'hFF, 8'hFF, 1'b1, 16'hFFFF);
    send_bytes(96'hFFFF_1000_0102, 6);
    repeat (6) queue_buffer();
    wait_quiet();

    while (rand_items < 700) begin
      case ($urandom_range(0, 5))
        0: target = 0;
        1: target = 16'hFFFF;
        2: target = $urandom_range(1, 4);
        default: target = $urandom_range(0, 24);
      endcase
      set_config($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1),
                 target);
      idle_on = (rand_items < 600) && ($urandom_range(0, 3) != 0);
      target = rand_items + $urandom_range(50, 110);
      while (rand_items < target) queue_buffer();
      wait_quiet();
    end

    repeat (10) @(posedge clk);
    $display("Scanned %0d bytes over %0d register settings.", bytes_taken, settings);
    $display("Results: %0d value bytes, %0d records found, %0d searches not found.",
             value_count, found_count, miss_count);
    if (err_count == 0)
      $display("tlv_record_value_extractor test passed");
    else
      $display("tlv_record_value_extractor test failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding.", pending_results.size());
    $display("tlv_record_value_extractor test failed");
    $finish;
  end

endmodule
